// File: design/opg_pkg.sv
// Shared types and constants for the orbit position generator.
// Depends on nothing; used by opg_regs and orbit_position_generator_unit.
`default_nettype none

package opg_pkg;

	// Table size default and fixed field widths
	localparam int unsigned SINE_ENTRIES_DEFAULT = 1024;
	localparam int unsigned ANGLE_W = 41;
	localparam int unsigned SPEED_W = 36;
	localparam int unsigned LEN_W   = 32;

	// APB geometry: 64-bit data, registers every 8 bytes
	localparam int unsigned APB_AW = 6;
	localparam int unsigned APB_DW = 64;

	// Register indexes
	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_ORBIT_MODE   = 3'd1;
	localparam logic [2:0] REG_CENTER_X     = 3'd2;
	localparam logic [2:0] REG_CENTER_Z     = 3'd3;
	localparam logic [2:0] REG_START_RADIUS = 3'd4;
	localparam logic [2:0] REG_START_HEIGHT = 3'd5;
	localparam logic [2:0] REG_START_SPEED  = 3'd6;

	// Orbit mode codes
	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_CW   = 2'd1;
	localparam logic [1:0] MODE_CCW  = 2'd2;

	// Fixed-point steps and limits
	localparam logic signed [LEN_W-1:0] LEN_STEP   = 32'sd655;
	localparam logic [SPEED_W-1:0]      SPEED_STEP = 36'd42950;
	localparam logic [SPEED_W-1:0]      SPEED_MAX  = 36'hF_FFFF_FFFF;
	localparam logic [ANGLE_W-1:0]      DEG359     = 41'(64'd359 << 32);

	// Reciprocal of 360 scaled by 2^40, for the table index
	localparam int unsigned     DIV360_SHIFT = 40;
	localparam logic [31:0]     DIV360_RECIP = 32'((64'd1 << 40) / 64'd360);

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic                     enable;
		logic [1:0]               orbit_mode;
		logic signed [LEN_W-1:0]  center_x;
		logic signed [LEN_W-1:0]  center_z;
		logic signed [LEN_W-1:0]  start_radius;
		logic signed [LEN_W-1:0]  start_height;
		logic [SPEED_W-1:0]       start_speed;
	} opg_cfg_t;

	// Clip a 34-bit signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/opg_regs.sv
// APB configuration registers of the orbit position generator.
// Depends on opg_pkg for register indexes and the config struct.
`default_nettype none

module opg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [opg_pkg::APB_AW-1:0]   paddr,
	input  wire logic [opg_pkg::APB_DW-1:0]   pwdata,
	output logic      [opg_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output opg_pkg::opg_cfg_t                 cfg
);

	logic [2:0]         reg_idx;
	logic               wr_en;
	opg_pkg::opg_cfg_t  cfg_q;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable       <= 1'b1;
			cfg_q.orbit_mode   <= opg_pkg::MODE_HOLD;
			cfg_q.center_x     <= '0;
			cfg_q.center_z     <= '0;
			cfg_q.start_radius <= '0;
			cfg_q.start_height <= '0;
			cfg_q.start_speed  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				opg_pkg::REG_ENABLE:       cfg_q.enable       <= pwdata[0];
				opg_pkg::REG_ORBIT_MODE:   cfg_q.orbit_mode   <= pwdata[1:0];
				opg_pkg::REG_CENTER_X:     cfg_q.center_x     <= pwdata[31:0];
				opg_pkg::REG_CENTER_Z:     cfg_q.center_z     <= pwdata[31:0];
				opg_pkg::REG_START_RADIUS: cfg_q.start_radius <= pwdata[31:0];
				opg_pkg::REG_START_HEIGHT: cfg_q.start_height <= pwdata[31:0];
				opg_pkg::REG_START_SPEED:  cfg_q.start_speed  <= pwdata[35:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			opg_pkg::REG_ENABLE:       prdata = 64'(cfg_q.enable);
			opg_pkg::REG_ORBIT_MODE:   prdata = 64'(cfg_q.orbit_mode);
			opg_pkg::REG_CENTER_X:     prdata = 64'(unsigned'(cfg_q.center_x));
			opg_pkg::REG_CENTER_Z:     prdata = 64'(unsigned'(cfg_q.center_z));
			opg_pkg::REG_START_RADIUS: prdata = 64'(unsigned'(cfg_q.start_radius));
			opg_pkg::REG_START_HEIGHT: prdata = 64'(unsigned'(cfg_q.start_height));
			opg_pkg::REG_START_SPEED:  prdata = 64'(cfg_q.start_speed);
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/opg_sine_rom.sv
// Sine table ROM, Q1.30 samples over one turn, two registered read ports.
// Contents are built at elaboration by a truncated integer series; no package use.
`default_nettype none

module opg_sine_rom #(
	parameter int unsigned ENTRIES = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(ENTRIES)-1:0]   addr_a,
	input  wire logic [$clog2(ENTRIES)-1:0]   addr_b,
	output logic signed [31:0]                data_a,
	output logic signed [31:0]                data_b
);

	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;

	// Sine of r quarter turns, r in Q0.30, result Q1.30
	function automatic logic [63:0] quarter_sine(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = (r * HALFPI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd272;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		return (s > Q30_ONE) ? Q30_ONE : s;
	endfunction

	// Table entry k: fold the phase into one quadrant and fix the sign
	function automatic logic signed [31:0] sine_at(input int unsigned k);
		logic [63:0] p;
		logic [63:0] r;
		logic [63:0] s;
		logic [1:0]  q;
		p = (64'(k) << 32) / 64'(ENTRIES);
		q = p[31:30];
		r = {34'd0, p[29:0]};
		s = q[0] ? quarter_sine(Q30_ONE - r) : quarter_sine(r);
		return q[1] ? -signed'(s[31:0]) : signed'(s[31:0]);
	endfunction

	logic signed [31:0] rom [ENTRIES];

	for (genvar k = 0; k < ENTRIES; k++) begin : g_rom
		assign rom[k] = sine_at(k);
	end

	// Registered reads, held while the next stage stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_a <= rom[addr_a];
			data_b <= rom[addr_b];
		end
	end

endmodule

`default_nettype wire

// File: design/orbit_position_generator_unit.sv
// Orbit position generator top level: orbit state, index pipeline, position math.
// Depends on opg_pkg, opg_regs and opg_sine_rom.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  s_*      | in        | s_tvalid / s_tready        | s_tuser: func; s_tdata: keys
//  m_*      | out       | m_tvalid / m_tready        | m_tdata: pos_x, pos_y, pos_z
//  apb      | in/out    | psel, penable, pwrite, rdy | paddr, pwdata, prdata (64 bit)
//
// One item is accepted per cycle while s_tready is high; orbit state updates in the cycle of acceptance.
// A position then passes through the registered stages angle register, scale by table size,
// reciprocal multiply by 1/360, ROM read, radius multiply, add and clip.
// Each stage holds when the one after it is full and stalled, so m_tready
// reaches s_tready through the stage valid chain. Restart and disabled ticks
// give no result. Reset clears state and the stage valid bits; no clearing pass.
`default_nettype none

module orbit_position_generator_unit #(
	parameter int unsigned SINE_ENTRIES = opg_pkg::SINE_ENTRIES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // key_closer, key_farther, key_up,
	                                                    // key_down, key_faster, key_slower, 0, 0
	input  wire logic                         s_tuser,  // func
	// output stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [95:0]                       m_tdata,  // pos_x, pos_y, pos_z
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [opg_pkg::APB_AW-1:0]   paddr,
	input  wire logic [opg_pkg::APB_DW-1:0]   pwdata,
	output logic      [opg_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);

	localparam int unsigned IW = $clog2(SINE_ENTRIES);
	localparam int unsigned NW = $clog2(SINE_ENTRIES + 1);
	localparam int unsigned UW = $clog2(360 * SINE_ENTRIES);
	localparam int unsigned AW = opg_pkg::ANGLE_W;
	localparam int unsigned SW = opg_pkg::SPEED_W;
	localparam logic [NW-1:0] SINE_N  = NW'(SINE_ENTRIES);
	localparam logic [IW:0]   QUARTER = (IW+1)'(SINE_ENTRIES / 4);
	localparam logic [IW:0]   WRAP_N  = (IW+1)'(SINE_ENTRIES);

	opg_pkg::opg_cfg_t cfg;

	opg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Orbit state
	logic [AW-1:0]        angle_q;
	logic [SW-1:0]        speed_q;
	logic signed [31:0]   radius_q;
	logic signed [31:0]   height_q;

	// Stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6     = !valid_s6 || m_tready;
	assign adv5     = !valid_s5 || adv6;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;

	logic accept, restart, tick;
	assign accept  = s_tvalid && s_tready;
	assign restart = accept && s_tuser;
	assign tick    = accept && !s_tuser && cfg.enable;

	// Step the angle with the clockwise and counter-clockwise wrap rules
	logic [AW-1:0] angle_sum;
	logic [AW-1:0] angle_nx;
	assign angle_sum = angle_q + AW'(speed_q);

	always_comb begin
		case (cfg.orbit_mode)
			opg_pkg::MODE_CW:
				angle_nx = (angle_sum > opg_pkg::DEG359) ? '0 : angle_sum;
			opg_pkg::MODE_CCW:
				angle_nx = (AW'(speed_q) > angle_q) ? opg_pkg::DEG359
				                                    : angle_q - AW'(speed_q);
			default:
				angle_nx = angle_q;
		endcase
	end

	// Key nudges, in the order closer, farther, up, down, faster, slower
	logic signed [31:0] radius_a, radius_nx, height_a, height_nx;
	logic [SW-1:0]      speed_a, speed_nx;

	always_comb begin
		radius_a  = s_tdata[0] ? opg_pkg::sat34(34'(radius_q) - 34'(opg_pkg::LEN_STEP))
		                       : radius_q;
		radius_nx = s_tdata[1] ? opg_pkg::sat34(34'(radius_a) + 34'(opg_pkg::LEN_STEP))
		                       : radius_a;
		height_a  = s_tdata[2] ? opg_pkg::sat34(34'(height_q) + 34'(opg_pkg::LEN_STEP))
		                       : height_q;
		height_nx = s_tdata[3] ? opg_pkg::sat34(34'(height_a) - 34'(opg_pkg::LEN_STEP))
		                       : height_a;
		if (s_tdata[4])
			speed_a = (speed_q > opg_pkg::SPEED_MAX - opg_pkg::SPEED_STEP) ? opg_pkg::SPEED_MAX
			                                                               : speed_q + opg_pkg::SPEED_STEP;
		else
			speed_a = speed_q;
		if (s_tdata[5])
			speed_nx = (speed_a < opg_pkg::SPEED_STEP) ? '0 : speed_a - opg_pkg::SPEED_STEP;
		else
			speed_nx = speed_a;
	end

	// Update orbit state on restart or enabled tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			speed_q  <= '0;
			radius_q <= '0;
			height_q <= '0;
		end else if (restart) begin
			angle_q  <= '0;
			speed_q  <= cfg.start_speed;
			radius_q <= cfg.start_radius;
			height_q <= cfg.start_height;
		end else if (tick) begin
			angle_q  <= angle_nx;
			speed_q  <= speed_nx;
			radius_q <= radius_nx;
			height_q <= height_nx;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= tick;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: new angle, old radius, adjusted height
	logic [AW-1:0]      angle_s1;
	logic signed [31:0] radius_s1, y_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			angle_s1  <= angle_nx;
			radius_s1 <= radius_q;
			y_s1      <= height_nx;
		end
	end

	// Stage 2: angle times table size, integer part
	logic [AW+NW-1:0]   scaled;
	logic [UW-1:0]      u_s2;
	logic signed [31:0] radius_s2, y_s2;
	assign scaled = (AW+NW)'(angle_s1) * (AW+NW)'(SINE_N);

	always_ff @(posedge clk) begin
		if (adv2) begin
			u_s2      <= scaled[32 +: UW];
			radius_s2 <= radius_s1;
			y_s2      <= y_s1;
		end
	end

	// Stage 3: approximate quotient by 360 via reciprocal
	logic [UW+31:0]     recip_prod;
	logic [UW+31:0]     q_full;
	logic [IW-1:0]      q0_s3;
	logic [UW-1:0]      u_s3;
	logic signed [31:0] radius_s3, y_s3;
	assign recip_prod = (UW+32)'(u_s2) * (UW+32)'(opg_pkg::DIV360_RECIP);
	assign q_full     = recip_prod >> opg_pkg::DIV360_SHIFT;

	always_ff @(posedge clk) begin
		if (adv3) begin
			q0_s3     <= q_full[IW-1:0];
			u_s3      <= u_s2;
			radius_s3 <= radius_s2;
			y_s3      <= y_s2;
		end
	end

	// Correct the quotient by one and form sine and cosine addresses
	logic [UW-1:0] rem;
	logic [IW-1:0] sin_idx, cos_idx;
	logic [IW:0]   cos_sum;
	assign rem     = u_s3 - UW'(q0_s3) * UW'(360);
	assign sin_idx = (rem >= UW'(360)) ? q0_s3 + IW'(1) : q0_s3;
	assign cos_sum = {1'b0, sin_idx} + QUARTER;
	assign cos_idx = (cos_sum >= WRAP_N) ? IW'(cos_sum - WRAP_N) : cos_sum[IW-1:0];

	// Stage 4: table read
	logic signed [31:0] sin_s4, cos_s4;
	logic signed [31:0] radius_s4, y_s4;

	opg_sine_rom #(
		.ENTRIES (SINE_ENTRIES)
	) u_sine_rom (
		.clk    (clk),
		.rd_en  (adv4),
		.addr_a (sin_idx),
		.addr_b (cos_idx),
		.data_a (sin_s4),
		.data_b (cos_s4)
	);

	always_ff @(posedge clk) begin
		if (adv4) begin
			radius_s4 <= radius_s3;
			y_s4      <= y_s3;
		end
	end

	// Stage 5: radius times sine and cosine
	logic signed [63:0] prod_x_s5, prod_z_s5;
	logic signed [31:0] y_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			prod_x_s5 <= radius_s4 * sin_s4;
			prod_z_s5 <= radius_s4 * cos_s4;
			y_s5      <= y_s4;
		end
	end

	// Stage 6: floor to Q16.16, add center, clip
	logic signed [33:0] sum_x, sum_z;
	logic signed [31:0] pos_x_s6, pos_y_s6, pos_z_s6;
	assign sum_x = 34'(cfg.center_x) + prod_x_s5[63:30];
	assign sum_z = 34'(cfg.center_z) + prod_z_s5[63:30];

	always_ff @(posedge clk) begin
		if (adv6) begin
			pos_x_s6 <= opg_pkg::sat34(sum_x);
			pos_y_s6 <= y_s5;
			pos_z_s6 <= opg_pkg::sat34(sum_z);
		end
	end

	assign m_tvalid = valid_s6;
	assign m_tdata  = {pos_z_s6, pos_y_s6, pos_x_s6};

endmodule

`default_nettype wire
